// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gocb_pkg.sv -----
// Types, constants and helpers shared by the checkerboard blend design.
package gocb_pkg;

    // Field and register widths
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int FRAC_BITS   = 16;
    localparam int CW_W        = 13;
    localparam int STEP_W      = 25;   // signed ramp step, magnitude below 2^24
    localparam int COLOR_W     = 32;
    localparam int ENTRY_IDX_W = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_DATA_W  = 3 * CH_W;

    // Register reset values
    localparam logic [COLOR_W-1:0] START_COLOR_RESET   = 32'h0000_00FF;
    localparam logic [COLOR_W-1:0] END_COLOR_RESET     = 32'hFFFF_FFFF;
    localparam logic [CH_W-1:0]    DARK_SHADE_RESET    = 8'h5F;
    localparam logic [CH_W-1:0]    LIGHT_SHADE_RESET   = 8'hA0;
    localparam logic [CH_W-1:0]    CHECK_MASK_RESET    = 8'h08;
    localparam logic [CW_W-1:0]    CONTENT_WIDTH_RESET = 13'd96;

    // Rounding term of the blend
    localparam logic [CH_W-1:0] BLEND_ROUND = 8'h80;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COLOR   = 3'd0,
        CFG_END_COLOR     = 3'd1,
        CFG_DARK_SHADE    = 3'd2,
        CFG_LIGHT_SHADE   = 3'd3,
        CFG_CHECK_MASK    = 3'd4,
        CFG_CONTENT_WIDTH = 3'd5,
        CFG_USE_MAP       = 3'd6
    } cfg_index_t;

    // Step divider sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN,
        DIV_STORE
    } div_state_t;

    // Per-channel signed 9.16 ramp steps, lane 0 red .. lane 3 alpha
    typedef logic [NUM_CH-1:0][STEP_W-1:0] ramp_steps_t;

    // Channel k of an RRGGBBAA word: 0 red, 1 green, 2 blue, 3 alpha
    function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] c,
                                             input logic [1:0] k);
        logic [CH_W-1:0] r;
        case (k)
            2'd0:    r = c[31:24];
            2'd1:    r = c[23:16];
            2'd2:    r = c[15:8];
            default: r = c[7:0];
        endcase
        return r;
    endfunction

endpackage

// ----- design/gocb_step_div.sv -----
// Shared restoring divider that derives the ramp and map steps from the registers.
`include "assert_macros.svh"

module gocb_step_div #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [gocb_pkg::COLOR_W-1:0]               start_color,
    input  logic [gocb_pkg::COLOR_W-1:0]               end_color,
    input  logic [gocb_pkg::CW_W-1:0]                  content_width,
    output logic                                       busy,
    output gocb_pkg::ramp_steps_t                      ramp_step,
    output logic [$clog2(MAP_DEPTH+1)+gocb_pkg::FRAC_BITS-1:0] map_step
);
    import gocb_pkg::*;

    localparam int MAP_Q_W   = $clog2(MAP_DEPTH + 1) + FRAC_BITS;
    localparam int CH_NUM_W  = CH_W + FRAC_BITS;
    localparam int NUM_W     = (MAP_Q_W > CH_NUM_W) ? MAP_Q_W : CH_NUM_W;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int JOB_W     = $clog2(NUM_CH + 1);
    localparam int CH_SEL_W  = $clog2(NUM_CH);
    localparam logic [JOB_W-1:0] MAP_JOB = JOB_W'(NUM_CH);
    localparam logic [NUM_W-1:0] MAP_NUM = NUM_W'(MAP_DEPTH) << FRAC_BITS;

    div_state_t           state_reg, state_next;
    logic [JOB_W-1:0]     job_reg, job_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [CW_W-1:0]      rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    ramp_steps_t          ramp_step_reg, ramp_step_next;
    logic [MAP_Q_W-1:0]   map_step_reg, map_step_next;

    logic [CW_W-1:0]      divisor;
    logic [CH_W-1:0]      c0, c1, mag;
    logic                 c_neg;
    logic [CW_W:0]        rem_shift, rem_sub;
    logic                 rem_ge;
    logic [STEP_W-1:0]    q_step;

    // A zero width counts as one
    assign divisor = (content_width == '0) ? CW_W'(1) : content_width;

    // Channel difference of the current job
    assign c0    = chan(start_color, job_reg[CH_SEL_W-1:0]);
    assign c1    = chan(end_color, job_reg[CH_SEL_W-1:0]);
    assign c_neg = (c1 < c0);
    assign mag   = c_neg ? (c0 - c1) : (c1 - c0);

    // One quotient bit per cycle
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign q_step    = STEP_W'(quo_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:  state_next = DIV_IDLE;
            DIV_LOAD:  state_next = DIV_RUN;
            DIV_RUN:   if (cnt_reg == '0) state_next = DIV_STORE;
            DIV_STORE: state_next = (job_reg == MAP_JOB) ? DIV_IDLE : DIV_LOAD;
            default:   state_next = DIV_IDLE;
        endcase
        if (start)
            state_next = DIV_LOAD;
    end

    // Outputs
    always_comb
    begin
        busy      = (state_reg != DIV_IDLE) || start;
        ramp_step = ramp_step_reg;
        map_step  = map_step_reg;
    end

    // Datapath next values
    always_comb
    begin
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        ramp_step_next = ramp_step_reg;
        map_step_next  = map_step_reg;
        case (state_reg)
            DIV_LOAD:
            begin
                num_next = (job_reg == MAP_JOB) ? MAP_NUM : NUM_W'({mag, FRAC_BITS'(0)});
                neg_next = (job_reg != MAP_JOB) && c_neg;
                rem_next = '0;
                quo_next = '0;
                cnt_next = CNT_W'(NUM_W - 1);
            end
            DIV_RUN:
            begin
                num_next = num_reg << 1;
                rem_next = rem_ge ? rem_sub[CW_W-1:0] : rem_shift[CW_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DIV_STORE:
            begin
                if (job_reg == MAP_JOB)
                    map_step_next = quo_reg[MAP_Q_W-1:0];
                else
                    ramp_step_next[job_reg[CH_SEL_W-1:0]] = neg_reg ? -q_step : q_step;
                job_next = job_reg + JOB_W'(1);
            end
            default: ;
        endcase
        if (start)
            job_next = '0;
    end

    // Sequencer state; reset launches the first pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_LOAD;
            job_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        ramp_step_reg <= ramp_step_next;
        map_step_reg  <= map_step_next;
    end

    `ASSERT_NEXT(a_steps_hold_idle, clk, rst_n, !busy, $stable(ramp_step_reg) && $stable(map_step_reg), "steps changed while divider idle")
    `ASSERT_IMPLIES(a_job_range, clk, rst_n, state_reg != DIV_IDLE, job_reg <= MAP_JOB, "divider job out of range")
    `ASSERT_NEXT(a_restart, clk, rst_n, start, state_reg == DIV_LOAD && job_reg == '0, "divider did not restart")

endmodule

// ----- design/gradient_over_checkerboard.sv -----
// Top level: colour ramp or colour map blended over a checkerboard, one pixel per clock
// while neither the output stalls nor the step divider is busy.
// Input stream s_*: one request per accepted beat. s_tuser = 0 renders the pixel at
// (column, row); s_tuser = 1 writes entry_color into map entry entry_index and yields
// no result. Output stream m_*: one RGB result per render request, in request order.
// Registers are written on the cfg_* port by index, one write per cycle; the user must
// write them only while the stream is idle; the block itself does not enforce this.
// Throughput: one request per clock while s_tready is high. The pipeline has five
// register stages, and a result is valid when it reaches the stage 5 output register.
// The ramp and map steps are quotients by content_width, made by a shared divider
// that produces one bit per cycle: for each colour channel and then the map it loads,
// runs NUM_W = max(24, clog2(MAP_DEPTH+1) + 16) quotient bits and stores. That pass
// runs after reset and after each write of start_color, end_color or content_width;
// s_tready stays low while it runs.
// Reset loads the register defaults; the map contents are undefined until written.
// A stall on m_tready holds the output register; earlier stages keep filling their
// empty slots, so a stall drops s_tready only when every stage holds a request.
`include "assert_macros.svh"

module gradient_over_checkerboard #(
    parameter int MAP_DEPTH  = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // column, row, entry_index, entry_color, zero pad
    input  logic [((2*COORD_BITS + gocb_pkg::ENTRY_IDX_W + gocb_pkg::COLOR_W + 7)/8)*8-1:0]
                                                  s_tdata,
    // command
    input  logic                                  s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // red, green, blue
    output logic [gocb_pkg::OUT_DATA_W-1:0]       m_tdata,
    // Register write port
    input  logic                                  cfg_we,
    input  logic [gocb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gocb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gocb_pkg::*;

    localparam int MAP_Q_W   = $clog2(MAP_DEPTH + 1) + FRAC_BITS;
    localparam int MAP_IDX_W = $clog2(MAP_DEPTH);
    localparam int MPROD_W   = COORD_BITS + MAP_Q_W;
    localparam int QI_W      = MPROD_W - FRAC_BITS;
    localparam int PROD_W    = COORD_BITS + 1 + STEP_W;
    localparam int V_W       = PROD_W + 1;
    localparam int CHK_W     = (COORD_BITS < CH_W) ? COORD_BITS : CH_W;
    localparam int T_W       = 2 * CH_W + 1;
    localparam int P_W       = 2 * (CH_W + 1);
    localparam int U_W       = T_W + 1;
    localparam int NUM_RGB   = 3;

    // Configuration registers
    logic [COLOR_W-1:0] start_color_reg, end_color_reg;
    logic [CH_W-1:0]    dark_shade_reg, light_shade_reg, check_mask_reg;
    logic [CW_W-1:0]    content_width_reg;
    logic               use_map_reg;

    // Step divider
    logic               div_start, div_busy;
    ramp_steps_t        ramp_step;
    logic [MAP_Q_W-1:0] map_step;

    // Stage load enables
    logic ld1, ld2, ld3, ld4, ld5;

    // Stage 1: captured request
    logic                   v1_reg, cmd1_reg;
    logic [COORD_BITS-1:0]  col1_reg, row1_reg;
    logic [ENTRY_IDX_W-1:0] eidx1_reg;
    logic [COLOR_W-1:0]     ecol1_reg;

    // Stage 2: products and checker grey
    logic                     v2_reg, cmd2_reg;
    logic signed [PROD_W-1:0] gprod2_reg [NUM_CH];
    logic signed [PROD_W-1:0] gprod_next [NUM_CH];
    logic [MPROD_W-1:0]       mprod2_reg;
    logic [CH_W-1:0]          bg2_reg, bg_next;
    logic [ENTRY_IDX_W-1:0]   eidx2_reg;
    logic [COLOR_W-1:0]       ecol2_reg;

    // Stage 3: ramp channels and map read
    logic                 v3_reg;
    logic [CH_W-1:0]      grad3_reg [NUM_CH];
    logic [CH_W-1:0]      grad_next [NUM_CH];
    logic [COLOR_W-1:0]   mem_rd3_reg;
    logic [CH_W-1:0]      bg3_reg;
    logic [QI_W-1:0]      qidx;
    logic [MAP_IDX_W-1:0] rd_addr, wr_addr;
    logic                 mem_we;

    // Stage 4: scaled differences
    logic                         v4_reg;
    logic [NUM_RGB-1:0][T_W-1:0]  t4_reg, t_next;
    logic [CH_W-1:0]              bg4_reg;

    // Stage 5: output register
    logic                     v5_reg;
    logic [OUT_DATA_W-1:0]    out5_reg, out_next;

    // Colour map
    logic [COLOR_W-1:0] map_mem [MAP_DEPTH];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg   <= START_COLOR_RESET;
            end_color_reg     <= END_COLOR_RESET;
            dark_shade_reg    <= DARK_SHADE_RESET;
            light_shade_reg   <= LIGHT_SHADE_RESET;
            check_mask_reg    <= CHECK_MASK_RESET;
            content_width_reg <= CONTENT_WIDTH_RESET;
            use_map_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_COLOR:   start_color_reg   <= cfg_data[COLOR_W-1:0];
                CFG_END_COLOR:     end_color_reg     <= cfg_data[COLOR_W-1:0];
                CFG_DARK_SHADE:    dark_shade_reg    <= cfg_data[CH_W-1:0];
                CFG_LIGHT_SHADE:   light_shade_reg   <= cfg_data[CH_W-1:0];
                CFG_CHECK_MASK:    check_mask_reg    <= cfg_data[CH_W-1:0];
                CFG_CONTENT_WIDTH: content_width_reg <= cfg_data[CW_W-1:0];
                CFG_USE_MAP:       use_map_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Steps must be recomputed when any of their operands changes
    assign div_start = cfg_we && (cfg_index == CFG_START_COLOR ||
                                  cfg_index == CFG_END_COLOR ||
                                  cfg_index == CFG_CONTENT_WIDTH);

    gocb_step_div #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_step_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .start_color   (start_color_reg),
        .end_color     (end_color_reg),
        .content_width (content_width_reg),
        .busy          (div_busy),
        .ramp_step     (ramp_step),
        .map_step      (map_step)
    );

    // A stage loads when it is empty or its content moves on
    assign ld5      = !v5_reg || m_tready;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1 && !div_busy;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= s_tvalid && s_tready;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg && !cmd2_reg;   // map writes end here
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: unpack the request
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            cmd1_reg  <= s_tuser;
            col1_reg  <= s_tdata[COORD_BITS-1:0];
            row1_reg  <= s_tdata[2*COORD_BITS-1 -: COORD_BITS];
            eidx1_reg <= s_tdata[2*COORD_BITS +: ENTRY_IDX_W];
            ecol1_reg <= s_tdata[2*COORD_BITS+ENTRY_IDX_W +: COLOR_W];
        end
    end

    // Stage 2 logic: column times step per lane, checker grey
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
            gprod_next[k] = $signed({1'b0, col1_reg}) * $signed(ramp_step[k]);
        bg_next = (|((col1_reg[CHK_W-1:0] ^ row1_reg[CHK_W-1:0]) & check_mask_reg[CHK_W-1:0]))
                  ? dark_shade_reg : light_shade_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            cmd2_reg   <= cmd1_reg;
            for (int k = 0; k < NUM_CH; k++)
                gprod2_reg[k] <= gprod_next[k];
            mprod2_reg <= col1_reg * map_step;
            bg2_reg    <= bg_next;
            eidx2_reg  <= eidx1_reg;
            ecol2_reg  <= ecol1_reg;
        end
    end

    // Stage 3 logic: add the start channel and clamp to 0..255
    always_comb
    begin
        logic [V_W-1:0] vsum;
        for (int k = 0; k < NUM_CH; k++)
        begin
            vsum = {gprod2_reg[k][PROD_W-1], gprod2_reg[k]}
                   + V_W'({chan(start_color_reg, 2'(k)), FRAC_BITS'(0)});
            if (vsum[V_W-1])
                grad_next[k] = '0;
            else if (|vsum[V_W-2:FRAC_BITS+CH_W])
                grad_next[k] = '1;
            else
                grad_next[k] = vsum[FRAC_BITS +: CH_W];
        end
    end

    // Map index clamps to the last entry
    assign qidx    = mprod2_reg[MPROD_W-1:FRAC_BITS];
    assign rd_addr = (qidx >= QI_W'(MAP_DEPTH)) ? MAP_IDX_W'(MAP_DEPTH - 1)
                                                : qidx[MAP_IDX_W-1:0];
    assign wr_addr = MAP_IDX_W'(eidx2_reg);
    assign mem_we  = ld3 && v2_reg && cmd2_reg && (32'(eidx2_reg) < MAP_DEPTH);

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            for (int k = 0; k < NUM_CH; k++)
                grad3_reg[k] <= grad_next[k];
            bg3_reg <= bg2_reg;
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[wr_addr] <= ecol2_reg;
        if (ld3)
            mem_rd3_reg <= map_mem[rd_addr];
    end

    // Stage 4 logic: t = (c - bg) * a per colour channel
    always_comb
    begin
        logic [CH_W-1:0]       cs [NUM_CH];
        logic signed [CH_W:0]  dif;
        logic signed [P_W-1:0] prod;
        for (int k = 0; k < NUM_CH; k++)
            cs[k] = use_map_reg ? chan(mem_rd3_reg, 2'(k)) : grad3_reg[k];
        for (int k = 0; k < NUM_RGB; k++)
        begin
            dif       = $signed({1'b0, cs[k]}) - $signed({1'b0, bg3_reg});
            prod      = dif * $signed({1'b0, cs[NUM_CH-1]});
            t_next[k] = prod[T_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            t4_reg  <= t_next;
            bg4_reg <= bg3_reg;
        end
    end

    // Stage 5 logic: bg + ((t + (t >> 8) + 128) >> 8), kept modulo 256
    always_comb
    begin
        logic [U_W-1:0] u;
        for (int k = 0; k < NUM_RGB; k++)
        begin
            u = {t4_reg[k][T_W-1], t4_reg[k]}
                + {{(U_W-T_W+CH_W){t4_reg[k][T_W-1]}}, t4_reg[k][T_W-1:CH_W]}
                + U_W'(BLEND_ROUND);
            out_next[k*CH_W +: CH_W] = bg4_reg + u[CH_W +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
            out5_reg <= out_next;
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = out5_reg;

    `ASSERT_NEXT(a_write_no_result, clk, rst_n, v2_reg && cmd2_reg && ld3, !v3_reg, "map write entered the blend stages")
    `ASSERT_NEXT(a_blend_stage_holds, clk, rst_n, v4_reg && !ld4, v4_reg && $stable(t4_reg) && $stable(bg4_reg), "stalled blend stage changed")
    `ASSERT_IMPLIES(a_rd_addr_range, clk, rst_n, v2_reg && !cmd2_reg, 32'(rd_addr) < MAP_DEPTH, "map read address beyond depth")

endmodule

// ----- bench/tb_gradient_over_checkerboard.sv -----
// Self-checking bench for the ramp/map over checkerboard pixel block, directed and random traffic.
`timescale 1ns / 1ps

module tb_gradient_over_checkerboard;
    import gocb_pkg::*;

    localparam int MAP_ENTRIES  = 1024;
    localparam int COORD        = 12;
    localparam int IN_W         = ((2*COORD + ENTRY_IDX_W + COLOR_W + 7)/8)*8;
    localparam int FRAC         = 16;
    localparam int PIPE_SETTLE  = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int GAP_PERCENT  = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam logic CMD_RENDER    = 1'b0;
    localparam logic CMD_MAP_WRITE = 1'b1;

    // red in the low byte, as on m_tdata
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the registers and the color map
    logic [COLOR_W-1:0] start_rgba;
    logic [COLOR_W-1:0] end_rgba;
    logic [CH_W-1:0]    dark_grey;
    logic [CH_W-1:0]    light_grey;
    logic [CH_W-1:0]    cell_mask;
    logic [CW_W-1:0]    span;
    logic               map_mode;
    logic [COLOR_W-1:0] palette [MAP_ENTRIES];
    bit                 palette_loaded [MAP_ENTRIES];

    pixel_t expected_pixels [$];
    int     mismatches;
    int     cycle_count;
    int     hold_cycles;
    bit     tx_gaps;
    bit     rx_gaps;

    gradient_over_checkerboard i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Pixel predictor
    // ---------------------------------------------------------------

    // one ramp channel: 16.16 step, clamped to 0..255
    function automatic logic [CH_W-1:0] ramp_level(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                                                   logic [COORD-1:0] col, longint w);
        longint step;
        longint level;
        step  = ((longint'(c1) - longint'(c0)) * 65536) / w;
        level = longint'(c0) * 65536 + longint'(col) * step;
        if (level < 0)
            return '0;
        level = level / 65536;
        return (level > 255) ? 8'hFF : level[7:0];
    endfunction

    // alpha blend over grey with the x/255 approximation
    function automatic logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] c, logic [CH_W-1:0] a,
                                                      logic [CH_W-1:0] bg);
        longint t;
        longint sum;
        t   = (longint'(c) - longint'(bg)) * longint'(a);
        sum = longint'(bg) + ((t + (t >>> 8) + longint'(BLEND_ROUND)) >>> 8);
        return sum[7:0];
    endfunction

    function automatic int unsigned palette_slot(logic [COORD-1:0] col);
        longint unsigned w;
        longint unsigned stride;
        longint unsigned slot;
        w      = (span == 0) ? 1 : span;
        stride = (longint'(MAP_ENTRIES) << FRAC) / w;
        slot   = (longint'(col) * stride) >> FRAC;
        return (slot >= MAP_ENTRIES) ? MAP_ENTRIES - 1 : int'(slot);
    endfunction

    function automatic pixel_t predict_pixel(logic [COORD-1:0] col, logic [COORD-1:0] row);
        logic [COLOR_W-1:0] rgba;
        logic [CH_W-1:0]    grey;
        longint             w;
        pixel_t             px;
        w = (span == 0) ? 1 : longint'(span);
        if (map_mode)
            rgba = palette[palette_slot(col)];
        else
        begin
            rgba[31:24] = ramp_level(start_rgba[31:24], end_rgba[31:24], col, w);
            rgba[23:16] = ramp_level(start_rgba[23:16], end_rgba[23:16], col, w);
            rgba[15:8]  = ramp_level(start_rgba[15:8],  end_rgba[15:8],  col, w);
            rgba[7:0]   = ramp_level(start_rgba[7:0],   end_rgba[7:0],   col, w);
        end
        grey = (((col & cell_mask) ^ (row & cell_mask)) != 0) ? dark_grey : light_grey;
        px.red   = blend_channel(rgba[31:24], rgba[7:0], grey);
        px.green = blend_channel(rgba[23:16], rgba[7:0], grey);
        px.blue  = blend_channel(rgba[15:8],  rgba[7:0], grey);
        return px;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // offer one request, wait for its handshake, then record what it implies
    task automatic send_request(logic cmd, logic [COORD-1:0] col, logic [COORD-1:0] row,
                                logic [ENTRY_IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
        logic [IN_W-1:0] word;
        word = '0;
        word[COORD-1:0]                                   = col;
        word[2*COORD-1:COORD]                             = row;
        word[2*COORD+ENTRY_IDX_W-1:2*COORD]               = idx;
        word[2*COORD+ENTRY_IDX_W+COLOR_W-1:2*COORD+ENTRY_IDX_W] = color;
        @(negedge clk);
        while (tx_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_MAP_WRITE)
        begin
            palette[idx]        = color;
            palette_loaded[idx] = 1'b1;
        end
        else
            expected_pixels.push_back(predict_pixel(col, row));
    endtask

    task automatic load_entry(logic [ENTRY_IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
        send_request(CMD_MAP_WRITE, COORD'($urandom_range(0, 4095)),
                     COORD'($urandom_range(0, 4095)), idx, color);
    endtask

    // render; in map mode an entry that was never loaded gets a random color first
    task automatic render(logic [COORD-1:0] col, logic [COORD-1:0] row);
        int unsigned slot;
        if (map_mode)
        begin
            slot = palette_slot(col);
            if (!palette_loaded[slot])
                load_entry(ENTRY_IDX_W'(slot), $urandom);
        end
        send_request(CMD_RENDER, col, row, ENTRY_IDX_W'($urandom_range(0, MAP_ENTRIES - 1)),
                     $urandom);
    endtask

    // drop valid, let every result come home and the pipe settle
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register writes
    // ---------------------------------------------------------------

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_START_COLOR:   start_rgba = value;
            CFG_END_COLOR:     end_rgba   = value;
            CFG_DARK_SHADE:    dark_grey  = value[CH_W-1:0];
            CFG_LIGHT_SHADE:   light_grey = value[CH_W-1:0];
            CFG_CHECK_MASK:    cell_mask  = value[CH_W-1:0];
            CFG_CONTENT_WIDTH: span       = value[CW_W-1:0];
            CFG_USE_MAP:       map_mode   = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(logic [COLOR_W-1:0] s, logic [COLOR_W-1:0] e,
                                 logic [CH_W-1:0] dk, logic [CH_W-1:0] lt,
                                 logic [CH_W-1:0] mk, logic [CW_W-1:0] wd, logic mp);
        quiesce();
        write_reg(CFG_START_COLOR, s);
        write_reg(CFG_END_COLOR, e);
        write_reg(CFG_DARK_SHADE, CFG_DATA_W'(dk));
        write_reg(CFG_LIGHT_SHADE, CFG_DATA_W'(lt));
        write_reg(CFG_CHECK_MASK, CFG_DATA_W'(mk));
        write_reg(CFG_CONTENT_WIDTH, CFG_DATA_W'(wd));
        write_reg(CFG_USE_MAP, CFG_DATA_W'(mp));
    endtask

    function automatic logic [CH_W-1:0] random_mask();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01 << $urandom_range(0, 7);
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_settings(logic [CW_W-1:0] wd, logic mp);
        load_settings($urandom, $urandom, CH_W'($urandom_range(0, 255)),
                      CH_W'($urandom_range(0, 255)), random_mask(), wd, mp);
    endtask

    // mixed traffic: mostly renders, some map loads, columns mostly inside the span
    task automatic run_traffic(int count);
        int unsigned w;
        logic [COORD-1:0] col;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15)
                load_entry(ENTRY_IDX_W'($urandom_range(0, MAP_ENTRIES - 1)), $urandom);
            else
            begin
                w = (span == 0) ? 1 : span;
                if ($urandom_range(0, 3) == 0)
                    col = COORD'($urandom_range(0, 4095));
                else
                    col = COORD'($urandom_range(0, (w > 4096) ? 4095 : w - 1));
                render(col, COORD'($urandom_range(0, 4095)));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset values: default ramp, checker cells and a column past the span
    task automatic test_reset_defaults();
        render(12'd0, 12'd0);
        render(12'd8, 12'd0);
        render(12'd95, 12'd8);
        render(12'd96, 12'd0);
        render(12'd4095, 12'd4095);
    endtask

    // steepest ramps, saturation both ways, zero span
    task automatic test_ramp_extremes();
        load_settings(32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h00, 13'd1, 1'b0);
        render(12'd0, 12'd0);
        render(12'd1, 12'd0);
        render(12'd4095, 12'd4095);
        load_settings(32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 8'h00, 8'hFF, 13'd4096, 1'b0);
        render(12'd0, 12'd4095);
        render(12'd4095, 12'd0);
        render(12'd2048, 12'd2048);
        // zero span counts as one pixel
        load_settings(32'h10A0_3080, 32'hF020_C0FF, 8'h5F, 8'hA0, 8'h08, 13'd0, 1'b0);
        render(12'd0, 12'd8);
        render(12'd2, 12'd0);
    endtask

    // map lookups at both ends of the table and index saturation
    task automatic test_map_lookup();
        quiesce();
        load_entry(10'd0, 32'hFFFF_FFFF);
        load_entry(10'd1, 32'h1234_5680);
        load_entry(10'd1023, 32'h0000_0000);
        load_settings(32'h0000_00FF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h80, 13'd1, 1'b1);
        render(12'd0, 12'd0);
        render(12'd1, 12'd128);
        render(12'd4095, 12'd4095);
        quiesce();
        write_reg(CFG_CONTENT_WIDTH, 32'd4096);
        render(12'd4, 12'd0);
        render(12'd4095, 12'd0);
    endtask

    task automatic test_random_ramp();
        random_settings(13'd1, 1'b0);
        run_traffic(170);
        random_settings(13'd4096, 1'b0);
        run_traffic(170);
        random_settings(CW_W'($urandom_range(1, 128)), 1'b0);
        run_traffic(170);
        random_settings(CW_W'($urandom_range(1, 4096)), 1'b0);
        run_traffic(170);
    endtask

    // map mode also loads every entry it touches first, so fewer renders here
    task automatic test_random_map();
        random_settings(13'd1, 1'b1);
        run_traffic(120);
        random_settings(13'd4096, 1'b1);
        run_traffic(120);
        random_settings(CW_W'($urandom_range(1, 128)), 1'b1);
        run_traffic(120);
        random_settings(CW_W'($urandom_range(1, 4096)), 1'b1);
        run_traffic(120);
    endtask

    // long receiver hold-off with a full-rate sender, no random gaps
    task automatic test_backpressure();
        random_settings(CW_W'($urandom_range(1, 256)), 1'($urandom_range(0, 1)));
        tx_gaps     = 1'b0;
        rx_gaps     = 1'b0;
        hold_cycles = HOLD_CYCLES;
        run_traffic(200);
        quiesce();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // ready with random stalls, or held low during a hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready    <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                m_tready <= !(rx_gaps && $urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // compare each result with the oldest pending pixel
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        got = m_tdata;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: r=%02h g=%02h b=%02h",
                             $realtime, got.red, got.green, got.blue);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: pixel mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                                 $realtime, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        s_tvalid    = 1'b0;
        s_tuser     = CMD_RENDER;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_START_COLOR;
        cfg_data    = '0;
        rst_n       = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        hold_cycles = 0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        start_rgba  = START_COLOR_RESET;
        end_rgba    = END_COLOR_RESET;
        dark_grey   = DARK_SHADE_RESET;
        light_grey  = LIGHT_SHADE_RESET;
        cell_mask   = CHECK_MASK_RESET;
        span        = CONTENT_WIDTH_RESET;
        map_mode    = 1'b0;
        foreach (palette_loaded[i])
        begin
            palette_loaded[i] = 1'b0;
            palette[i]        = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_ramp_extremes();
        test_map_lookup();
        test_random_ramp();
        test_backpressure();
        test_random_map();

        quiesce();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/gocb_pkg.sv
design/gocb_step_div.sv
design/gradient_over_checkerboard.sv
bench/tb_gradient_over_checkerboard.sv
